FILE: sv/fpa2_pkg.sv
// Shared types and constants for the fixed-point atan2 core.
// No dependencies; compiled first.
package fpa2_pkg;

  localparam int FRAC_BITS_DEF   = 12;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH     = 11;
  // 1.0 in the internal angle format is a half turn, i.e. 2^10 output codes
  localparam int ANGLE_FRAC      = 10;

  // polynomial coefficients, scaled by 1e7
  localparam longint C1_NUM   = 778873;
  localparam longint C2_NUM   = 211035;
  localparam longint COEF_DEN = 10000000;

  // side info carried next to the quotient
  typedef struct packed {
    logic zneg;   // ratio is negative
    logic swap;   // |y| > |x|: ratio is x/y, angle mirrored about 45 deg
    logic flip;   // denominator negative: add a half turn
    logic zero;   // null vector
  } fpa2_side_t;

  // coefficient in frac-bit fixed point, truncated
  function automatic longint coef_fx(longint num, int frac);
    return (num << frac) / COEF_DEN;
  endfunction

endpackage

FILE: sv/fpa2_in_if.sv
// Input channel of the atan2 core: valid/ready plus the vector components.
// Depends on fpa2_pkg.
interface fpa2_in_if #(
  parameter int COORD_WIDTH = fpa2_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_x;

  modport source (output valid, coord_y, coord_x, input ready);
  modport sink   (input valid, coord_y, coord_x, output ready);
endinterface

FILE: sv/fpa2_out_if.sv
// Output channel of the atan2 core: valid/ready plus the angle.
// Depends on fpa2_pkg.
interface fpa2_out_if;
  import fpa2_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, angle, input ready);
  modport sink   (input valid, angle, output ready);
endinterface

FILE: sv/fixed_point_atan2_core.sv
// Top level of the fixed-point atan2 core: divider, polynomial, output register.
// Depends on fpa2_pkg, fpa2_in_if, fpa2_out_if, fpa2_div, fpa2_poly.
//
// Usage
//   coord_i carries one vector per transaction: coord_y and coord_x, signed
//   fixed point with FRAC_BITS fraction bits. angle_o carries the angle of
//   that vector, 2048 codes per full turn (1024 = half turn), wrapped to
//   0..2047. The null vector gives angle 0.
//   From input transaction to output valid an item passes one compare
//   stage, one restoring-division stage per quotient bit (FRAC_BITS + 1 of
//   them), four polynomial stages and the output register.
//   Throughput is one transaction per cycle unless every stage is full and
//   angle_o is stalled. Every stage has its own valid bit and loads whenever
//   it is empty or its successor moves, so bubbles close up under
//   backpressure and input keeps flowing while a result waits at angle_o.
//   When the receiver stalls, items pile up behind the output register;
//   coord_i.ready drops only once every stage holds an item.
//   Reset (rst_ni low, asynchronous) empties the pipeline; data registers
//   are not cleared and nothing is shown until valid items arrive.
module fixed_point_atan2_core #(
  parameter int FRAC_BITS   = fpa2_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = fpa2_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fpa2_in_if.sink           coord_i,
  fpa2_out_if.source        angle_o
);
  import fpa2_pkg::*;

  localparam int PW    = FRAC_BITS + 4;
  localparam int SHR   = (FRAC_BITS >= ANGLE_FRAC) ? FRAC_BITS - ANGLE_FRAC : 0;
  localparam int SHL   = (FRAC_BITS <  ANGLE_FRAC) ? ANGLE_FRAC - FRAC_BITS : 0;
  localparam int DEPTH = FRAC_BITS + 7;   // register stages holding an item
  localparam int CNTW  = $clog2(DEPTH + 1);

  // divider -> polynomial
  logic                 div_valid, div_ready;
  logic [FRAC_BITS:0]   div_quot;
  fpa2_side_t           div_side;

  // polynomial -> output register
  logic                 poly_valid, poly_ready;
  logic signed [PW-1:0] poly_r;
  logic                 poly_zero;

  fpa2_div #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (coord_i.valid),
    .in_ready_o  (coord_i.ready),
    .coord_y_i   (coord_i.coord_y),
    .coord_x_i   (coord_i.coord_x),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .quot_o      (div_quot),
    .side_o      (div_side)
  );

  fpa2_poly #(
    .FRAC_BITS (FRAC_BITS)
  ) u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .quot_i      (div_quot),
    .side_i      (div_side),
    .out_valid_o (poly_valid),
    .out_ready_i (poly_ready),
    .r_o         (poly_r),
    .zero_o      (poly_zero)
  );

  // output register: scale to 1024 per half turn (floor), wrap to 11 bits
  logic                   out_vld_q;
  logic [ANGLE_WIDTH-1:0] angle_d, angle_q;
  logic signed [PW-1:0]   scaled;

  assign poly_ready = !out_vld_q || angle_o.ready;
  assign scaled     = (poly_r >>> SHR) <<< SHL;
  assign angle_d    = poly_zero ? '0 : scaled[ANGLE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (poly_ready) begin
      out_vld_q <= poly_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poly_ready) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o.valid = out_vld_q;
  assign angle_o.angle = angle_q;

  // items in flight, for the checks below
  logic            in_fire, out_fire;
  logic [CNTW-1:0] cnt_d, cnt_q;

  assign in_fire  = coord_i.valid && coord_i.ready;
  assign out_fire = angle_o.valid && angle_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire && !out_fire) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (out_fire && !in_fire) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !angle_o.valid)
    else $error("result shown with nothing in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(DEPTH))
    else $error("more items in flight than pipeline stages");

  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !coord_i.ready |-> angle_o.valid && !angle_o.ready)
    else $error("input stalled while output side not blocked");

  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> cnt_q == $past(cnt_q) - CNTW'(1) + CNTW'($past(in_fire)))
    else $error("in-flight count out of step with transactions");

endmodule

FILE: sv/fpa2_div.sv
// Magnitude compare and pipelined restoring divider, one quotient bit per stage.
// Depends on fpa2_pkg.
module fpa2_div #(
  parameter int FRAC_BITS   = fpa2_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = fpa2_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [FRAC_BITS:0]            quot_o,
  output fpa2_pkg::fpa2_side_t          side_o
);
  import fpa2_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int QW   = FRAC_BITS + 1;
  localparam int NSTG = FRAC_BITS + 2;   // compare stage + one per quotient bit
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vin;
  logic [NSTG:0]   rdy;
  logic [W-1:0]    rem_q  [NSTG];
  logic [W-1:0]    den_q  [NSTG];
  logic [QW-1:0]   quo_q  [NSTG];
  fpa2_side_t      side_q [NSTG];

  // front end: magnitudes, branch select
  logic [W-1:0] ay, ax;
  fpa2_side_t   side_d;

  always_comb begin
    ay = coord_y_i[W-1] ? unsigned'(-coord_y_i) : unsigned'(coord_y_i);
    ax = coord_x_i[W-1] ? unsigned'(-coord_x_i) : unsigned'(coord_x_i);
    side_d.swap = ay > ax;
    side_d.zneg = coord_y_i[W-1] ^ coord_x_i[W-1];
    side_d.flip = side_d.swap ? coord_y_i[W-1] : coord_x_i[W-1];
    side_d.zero = (coord_y_i == '0) && (coord_x_i == '0);
  end

  // stall chain: a stage takes new data when empty or draining
  assign rdy[NSTG] = out_ready_i;
  assign vin       = {vld_q[NSTG-2:0], in_valid_i};

  for (genvar j = 0; j < NSTG; j++) begin : g_rdy
    assign rdy[j] = !vld_q[j] || rdy[j+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int j = 0; j < NSTG; j++) begin
        if (rdy[j]) begin
          vld_q[j] <= vin[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      rem_q[0]  <= side_d.swap ? ax : ay;
      den_q[0]  <= side_d.swap ? ay : ax;
      quo_q[0]  <= '0;
      side_q[0] <= side_d;
    end
  end

  for (genvar j = 1; j < NSTG; j++) begin : g_step
    logic [W-1:0] trial;
    logic [W:0]   diff;
    logic         take;

    // first step weighs 2^FRAC_BITS without a shift; remainder stays below divisor
    assign trial = (j == 1) ? rem_q[j-1] : {rem_q[j-1][W-2:0], 1'b0};
    assign diff  = {1'b0, trial} - {1'b0, den_q[j-1]};
    assign take  = !diff[W];

    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        rem_q[j]  <= take ? diff[W-1:0] : trial;
        den_q[j]  <= den_q[j-1];
        quo_q[j]  <= {quo_q[j-1][QW-2:0], take};
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign quot_o      = quo_q[NSTG-1];
  assign side_o      = side_q[NSTG-1];

  // smaller magnitude over larger never exceeds 1.0
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !side_o.zero |-> quot_o <= ONE_Q)
    else $error("quotient above 1.0");

endmodule

FILE: sv/fpa2_poly.sv
// Pipelined polynomial 0.25z - z(|z|-1)(C1+C2|z|) and octant correction.
// Depends on fpa2_pkg.
module fpa2_poly #(
  parameter int FRAC_BITS = fpa2_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [FRAC_BITS:0]          quot_i,
  input  fpa2_pkg::fpa2_side_t        side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [FRAC_BITS+3:0] r_o,
  output logic                        zero_o
);
  import fpa2_pkg::*;

  localparam int QW   = FRAC_BITS + 1;   // |z|
  localparam int ZW   = FRAC_BITS + 2;   // z
  localparam int MW   = FRAC_BITS + 2;   // z(|z|-1) after shift
  localparam int CW   = FRAC_BITS + 2;   // C1 + C2|z|
  localparam int PW   = FRAC_BITS + 4;   // angle before scaling
  localparam int NSTG = 4;

  localparam logic [QW-1:0]        ONE_Q  = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0]        C1_Q   = QW'(coef_fx(C1_NUM, FRAC_BITS));
  localparam logic [QW-1:0]        C2_Q   = QW'(coef_fx(C2_NUM, FRAC_BITS));
  localparam logic signed [PW-1:0] ONE_S  = PW'(64'sd1 << FRAC_BITS);
  localparam logic signed [PW-1:0] HALF_S = PW'(64'sd1 << (FRAC_BITS - 1));

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vin;
  logic [NSTG:0]   rdy;

  assign rdy[NSTG] = out_ready_i;
  assign vin       = {vld_q[NSTG-2:0], in_valid_i};

  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  // stage 1: signed z, |z|(1-|z|), C2|z|
  logic signed [ZW-1:0] zq;
  logic signed [ZW-1:0] z1_d, z1_q;
  logic [2*QW-1:0]      u1_d, u1_q;
  logic [2*QW-1:0]      p21_d, p21_q;
  fpa2_side_t           side1_q;

  assign zq    = signed'({1'b0, quot_i});
  assign z1_d  = side_i.zneg ? -zq : zq;
  assign u1_d  = (2*QW)'(quot_i) * (2*QW)'(ONE_Q - quot_i);
  assign p21_d = (2*QW)'(C2_Q) * (2*QW)'(quot_i);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      z1_q    <= z1_d;
      u1_q    <= u1_d;
      p21_q   <= p21_d;
      side1_q <= side_i;
    end
  end

  // stage 2: z(|z|-1) = +u for negative z, -u otherwise; floor shifts
  logic signed [2*QW:0] us2, s2;
  logic signed [MW-1:0] m2_d, m2_q;
  logic signed [CW-1:0] coef2_d, coef2_q;
  logic signed [ZW-1:0] lin2_q;
  fpa2_side_t           side2_q;

  assign us2     = signed'({1'b0, u1_q});
  assign s2      = side1_q.zneg ? us2 : -us2;
  assign m2_d    = s2[FRAC_BITS+MW-1:FRAC_BITS];
  assign coef2_d = signed'(CW'(C1_Q) + CW'(p21_q >> FRAC_BITS));

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      m2_q    <= m2_d;
      coef2_q <= coef2_d;
      lin2_q  <= z1_q >>> 2;   // 0.25 * z, floored
      side2_q <= side1_q;
    end
  end

  // stage 3: correction product
  logic signed [MW+CW-1:0] p3_d, p3_q;
  logic signed [ZW-1:0]    lin3_q;
  fpa2_side_t              side3_q;

  assign p3_d = m2_q * coef2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      p3_q    <= p3_d;
      lin3_q  <= lin2_q;
      side3_q <= side2_q;
    end
  end

  // stage 4: polynomial, mirror and half-turn correction
  logic signed [PW-1:0] corr4, poly4, rsel4, r4_d, r4_q;
  logic                 zero4_q;

  assign corr4 = p3_q[FRAC_BITS+PW-1:FRAC_BITS];
  assign poly4 = PW'(lin3_q) - corr4;
  assign rsel4 = side3_q.swap ? HALF_S - poly4 : poly4;
  assign r4_d  = side3_q.flip ? rsel4 + ONE_S : rsel4;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      r4_q    <= r4_d;
      zero4_q <= side3_q.zero;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign r_o         = r4_q;
  assign zero_o      = zero4_q;

endmodule

FILE: bench/fixed_point_atan2_core_tb.sv
`timescale 1ns / 100ps
// Testbench for fixed_point_atan2_core: random and directed vectors, angles checked
// against an in-bench fixed-point atan2 predictor. Depends on fpa2_pkg,
// fpa2_in_if, fpa2_out_if and the core itself.
module fixed_point_atan2_core_tb;
  import fpa2_pkg::*;

  localparam int  FRAC    = FRAC_BITS_DEF;
  localparam int  CW      = COORD_WIDTH_DEF;
  // core register stages between input transaction and angle valid
  localparam int  LATENCY = FRAC + 7;
  localparam int  N_RANDOM = 1800;
  // generous ceiling: every item with its longest gap, longest stall and the pipe
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  // fixed-point constants of the polynomial, truncated like the core's
  localparam longint FX_ONE     = longint'(1) << FRAC;
  localparam longint FX_QUARTER = FX_ONE / 4;
  localparam longint FX_HALF    = FX_ONE / 2;
  localparam longint FX_C1      = (C1_NUM << FRAC) / COEF_DEN;
  localparam longint FX_C2      = (C2_NUM << FRAC) / COEF_DEN;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } vec_t;

  logic clk_i;
  logic rst_ni;

  fpa2_in_if #(.COORD_WIDTH(CW)) coord_if ();
  fpa2_out_if                    angle_if ();

  fixed_point_atan2_core #(
    .FRAC_BITS  (FRAC),
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coord_i(coord_if),
    .angle_o(angle_if)
  );

  vec_t             pending_vecs[$];  // vectors not yet offered to the core
  logic [10:0]      angle_q[$];       // predicted angles, oldest first
  int               n_directed;
  int               sent_cnt;
  int               idle_cnt;
  int               stall_cnt;
  logic             in_calm;
  logic             out_calm;
  int               mismatches;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // product in fixed point, floored (>>> on a signed longint is a floor shift)
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  // 0.25z - z(|z|-1)(C1 + C2|z|) for a ratio z in [-1, 1]
  function automatic longint arc_poly(longint z);
    longint az;
    longint coef;
    az   = (z < 0) ? -z : z;
    coef = FX_C1 + fx_mul(FX_C2, az);
    return fx_mul(FX_QUARTER, z) - fx_mul(fx_mul(z, az - FX_ONE), coef);
  endfunction

  function automatic logic [10:0] vector_angle(logic signed [CW-1:0] y_in,
                                               logic signed [CW-1:0] x_in);
    longint yy;
    longint xx;
    longint ay;
    longint ax;
    longint r;
    longint scaled;
    yy = y_in;
    xx = x_in;
    if (yy == 0 && xx == 0) return '0;
    // magnitudes in 64 bits, so the most negative input keeps its true size
    ax = (xx < 0) ? -xx : xx;
    ay = (yy < 0) ? -yy : yy;
    // ties go to the y/x branch; SV division truncates toward zero
    if (ay <= ax) begin
      r = arc_poly((yy * FX_ONE) / xx);
      if (xx < 0) r += FX_ONE;
    end else begin
      r = FX_HALF - arc_poly((xx * FX_ONE) / yy);
      if (yy < 0) r += FX_ONE;
    end
    // 1.0 is a half turn, i.e. 1024 codes
    if (FRAC >= ANGLE_FRAC) scaled = r >>> (FRAC - ANGLE_FRAC);
    else                    scaled = r <<< (ANGLE_FRAC - FRAC);
    return scaled[10:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length for either side: mostly none or short, now and then long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [CW-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0: return CMIN;
      1: return CMAX;
      2: return CMIN + 1;
      3: return '0;
      4: return 1;
      5: return -1;
      default: return CW'(FX_ONE);
    endcase
  endfunction

  // mix of shapes: full range, short vectors, near-diagonal, near-axis,
  // extremes and vectors of random overall scale
  function automatic vec_t rand_vec();
    vec_t v;
    int   kind;
    int   sh;
    kind = $urandom_range(0, 99);
    v.y  = $urandom;
    v.x  = $urandom;
    if (kind < 30) begin
      // full-range bits as drawn
    end else if (kind < 48) begin
      v.y = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      v.x = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
    end else if (kind < 63) begin
      // magnitudes within a small delta: exercises the branch tie-break
      v.y = ($urandom_range(0, 1) ? v.x : -v.x) + ($signed($urandom_range(0, 8)) - 4);
    end else if (kind < 73) begin
      sh = $urandom_range(0, 30);
      if ($urandom_range(0, 1)) v.y = $urandom_range(0, 1) ? '0 : (v.y >>> sh);
      else                      v.x = $urandom_range(0, 1) ? '0 : (v.x >>> sh);
    end else if (kind < 83) begin
      v.y = pick_extreme();
      v.x = $urandom_range(0, 1) ? pick_extreme() : v.x;
    end else begin
      v.y = v.y >>> $urandom_range(0, 31);
      v.x = v.x >>> $urandom_range(0, 31);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, stimulus list and end of run
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    vec_t dir_vecs[$];
    // every input starts at a known value before reset releases
    rst_ni           = 1'b0;
    coord_if.valid   = 1'b0;
    coord_if.coord_y = '0;
    coord_if.coord_x = '0;
    angle_if.ready   = 1'b0;

    // directed: null vector, the four axes, unit steps, extremes of both
    // fields (most negative too), equal magnitudes in every quadrant and
    // near-ties either side of the diagonal
    dir_vecs = '{
      '{y: '0,            x: '0},
      '{y: '0,            x: 1},
      '{y: '0,            x: -1},
      '{y: 1,             x: '0},
      '{y: -1,            x: '0},
      '{y: '0,            x: CMAX},
      '{y: '0,            x: CMIN},
      '{y: CMAX,          x: '0},
      '{y: CMIN,          x: '0},
      '{y: CMIN,          x: CMIN},
      '{y: CMIN,          x: CMAX},
      '{y: CMAX,          x: CMIN},
      '{y: CMAX,          x: CMAX},
      '{y: CMIN + 1,      x: CMIN},
      '{y: 1,             x: 1},
      '{y: -1,            x: 1},
      '{y: 1,             x: -1},
      '{y: -1,            x: -1},
      '{y: 32'sd4096,     x: 32'sd4097},
      '{y: 32'sd4097,     x: 32'sd4096},
      '{y: -32'sd4096,    x: 32'sd12288},
      '{y: 32'sd12288,    x: -32'sd4096},
      '{y: -32'sd8191,    x: -32'sd8192}
    };
    foreach (dir_vecs[i]) pending_vecs.push_back(dir_vecs[i]);
    n_directed = dir_vecs.size();
    repeat (N_RANDOM) pending_vecs.push_back(rand_vec());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all stimulus accepted, then all angles back, then a quiet wait to catch
    // anything extra leaving the pipe
    while (pending_vecs.size() != 0 || coord_if.valid) @(posedge clk_i);
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (3 * LATENCY) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers pending vectors, records the prediction of each transaction.
  // After the directed set and again midway it holds off until the pipe has
  // drained completely.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    vec_t nxt;
    logic drain_hold;
    if (!rst_ni) begin
      coord_if.valid <= 1'b0;
      sent_cnt       <= 0;
      idle_cnt       <= 0;
      in_calm        <= 1'b0;
    end else begin
      if (coord_if.valid && coord_if.ready) begin
        angle_q.push_back(vector_angle(coord_if.coord_y, coord_if.coord_x));
      end
      // occasionally switch into or out of a stretch with no gaps
      if ($urandom_range(0, 63) == 0) in_calm <= !in_calm;

      drain_hold = (sent_cnt == n_directed || sent_cnt == n_directed + N_RANDOM / 2) &&
                   (angle_q.size() != 0);

      if (coord_if.valid && !coord_if.ready) begin
        // transaction pending: hold payload and valid
      end else if (idle_cnt > 0) begin
        coord_if.valid <= 1'b0;
        idle_cnt       <= idle_cnt - 1;
      end else if (pending_vecs.size() != 0 && !drain_hold) begin
        nxt = pending_vecs.pop_front();
        coord_if.valid   <= 1'b1;
        coord_if.coord_y <= nxt.y;
        coord_if.coord_x <= nxt.x;
        sent_cnt         <= sent_cnt + 1;
        idle_cnt         <= in_calm ? 0 : pick_pause();
      end else begin
        coord_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure on angle_o, each transaction checked against
  // the oldest prediction.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    logic [10:0] want;
    if (!rst_ni) begin
      angle_if.ready <= 1'b0;
      stall_cnt      <= 0;
      out_calm       <= 1'b0;
      mismatches     <= 0;
    end else begin
      if (angle_if.valid && angle_if.ready) begin
        if (angle_q.size() == 0) begin
          $error("angle: unexpected transaction, value %0d", angle_if.angle);
          mismatches <= mismatches + 1;
        end else begin
          want = angle_q.pop_front();
          if (angle_if.angle !== want) begin
            $error("angle: expected %0d, actual %0d", want, angle_if.angle);
            mismatches <= mismatches + 1;
          end
        end
      end

      if ($urandom_range(0, 63) == 0) out_calm <= !out_calm;

      if (stall_cnt > 0) begin
        angle_if.ready <= 1'b0;
        stall_cnt      <= stall_cnt - 1;
      end else begin
        angle_if.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 5) == 0) stall_cnt <= pick_pause();
      end
    end
  end

endmodule

FILE: filelist.f
sv/fpa2_pkg.sv
sv/fpa2_in_if.sv
sv/fpa2_out_if.sv
sv/fpa2_div.sv
sv/fpa2_poly.sv
sv/fixed_point_atan2_core.sv
bench/fixed_point_atan2_core_tb.sv
